// ===== rtl/core/scx_pkg.sv =====
`default_nettype none
package scx_pkg;

  localparam int CW     = 24;
  localparam int DW     = CW + 1;
  localparam int PW     = 2 * DW;
  localparam int DETW   = PW + 1;
  localparam int NDET   = 4;
  localparam int NCOORD = 8;
  localparam int IN_W   = NCOORD * CW;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = 5;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam int DET_BS = 0;
  localparam int DET_BE = 1;
  localparam int DET_AS = 2;
  localparam int DET_AE = 3;

  localparam int CRD_ASX = 0;
  localparam int CRD_ASZ = 1;
  localparam int CRD_AEX = 2;
  localparam int CRD_AEZ = 3;
  localparam int CRD_BSX = 4;
  localparam int CRD_BSZ = 5;
  localparam int CRD_BEX = 6;
  localparam int CRD_BEZ = 7;

  typedef enum logic [1:0] {
    SIDE_ON  = 2'd0,
    SIDE_POS = 2'd1,
    SIDE_NEG = 2'd2
  } side_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
  } det_ops_t;

  typedef struct packed {
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
  } det_prod_t;

  typedef det_ops_t  [NDET-1:0] det_ops_vec_t;
  typedef det_prod_t [NDET-1:0] det_prod_vec_t;
  typedef side_t     [NDET-1:0] side_vec_t;

  function automatic logic signed [DW-1:0] dsub(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y);
    return {x[CW-1], x} - {y[CW-1], y};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scx_diff.sv =====
`default_nettype none
module scx_diff (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_vld,
  output logic                          in_rdy,
  input  wire logic [scx_pkg::IN_W-1:0] in_coords,
  output logic                          out_vld,
  input  wire logic                     out_rdy,
  output scx_pkg::det_ops_vec_t         out_ops
);
  import scx_pkg::*;

  logic [CW-1:0] crd [NCOORD];
  logic          vld_r;
  det_ops_vec_t  ops_r;
  det_ops_vec_t  ops_nxt;

  always_comb begin
    for (int k = 0; k < NCOORD; k++) begin
      crd[k] = in_coords[k*CW +: CW];
    end
  end

  always_comb begin
    ops_nxt[DET_BS].a = dsub(crd[CRD_AEX], crd[CRD_ASX]);
    ops_nxt[DET_BS].d = dsub(crd[CRD_BSZ], crd[CRD_ASZ]);
    ops_nxt[DET_BS].b = dsub(crd[CRD_AEZ], crd[CRD_ASZ]);
    ops_nxt[DET_BS].c = dsub(crd[CRD_BSX], crd[CRD_ASX]);
    ops_nxt[DET_BE].a = dsub(crd[CRD_AEX], crd[CRD_ASX]);
    ops_nxt[DET_BE].d = dsub(crd[CRD_BEZ], crd[CRD_ASZ]);
    ops_nxt[DET_BE].b = dsub(crd[CRD_AEZ], crd[CRD_ASZ]);
    ops_nxt[DET_BE].c = dsub(crd[CRD_BEX], crd[CRD_ASX]);
    ops_nxt[DET_AS].a = dsub(crd[CRD_BEX], crd[CRD_BSX]);
    ops_nxt[DET_AS].d = dsub(crd[CRD_ASZ], crd[CRD_BSZ]);
    ops_nxt[DET_AS].b = dsub(crd[CRD_BEZ], crd[CRD_BSZ]);
    ops_nxt[DET_AS].c = dsub(crd[CRD_ASX], crd[CRD_BSX]);
    ops_nxt[DET_AE].a = dsub(crd[CRD_BEX], crd[CRD_BSX]);
    ops_nxt[DET_AE].d = dsub(crd[CRD_AEZ], crd[CRD_BSZ]);
    ops_nxt[DET_AE].b = dsub(crd[CRD_BEZ], crd[CRD_BSZ]);
    ops_nxt[DET_AE].c = dsub(crd[CRD_AEX], crd[CRD_BSX]);
  end

  assign in_rdy  = !vld_r || out_rdy;
  assign out_vld = vld_r;
  assign out_ops = ops_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      ops_r <= ops_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scx_mul.sv =====
`default_nettype none
module scx_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  output logic                       in_rdy,
  input  wire scx_pkg::det_ops_vec_t in_ops,
  output logic                       out_vld,
  input  wire logic                  out_rdy,
  output scx_pkg::det_prod_vec_t     out_prod
);
  import scx_pkg::*;

  logic          vld_r;
  det_prod_vec_t prod_r;
  det_prod_vec_t prod_nxt;

  always_comb begin
    for (int k = 0; k < NDET; k++) begin
      prod_nxt[k].p = PW'(in_ops[k].a) * PW'(in_ops[k].d);
      prod_nxt[k].q = PW'(in_ops[k].b) * PW'(in_ops[k].c);
    end
  end

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_prod = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scx_det.sv =====
`default_nettype none
module scx_det (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_vld,
  output logic                        in_rdy,
  input  wire scx_pkg::det_prod_vec_t in_prod,
  output logic                        out_vld,
  input  wire logic                   out_rdy,
  output scx_pkg::side_vec_t          out_sides
);
  import scx_pkg::*;

  logic                 vld_r;
  side_vec_t            sides_r;
  side_vec_t            sides_nxt;
  logic signed [DETW-1:0] det [NDET];

  always_comb begin
    for (int k = 0; k < NDET; k++) begin
      det[k] = {in_prod[k].p[PW-1], in_prod[k].p} - {in_prod[k].q[PW-1], in_prod[k].q};
      priority if (det[k] == '0) begin
        sides_nxt[k] = SIDE_ON;
      end else if (det[k][DETW-1]) begin
        sides_nxt[k] = SIDE_NEG;
      end else begin
        sides_nxt[k] = SIDE_POS;
      end
    end
  end

  assign in_rdy    = !vld_r || out_rdy;
  assign out_vld   = vld_r;
  assign out_sides = sides_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      sides_r <= sides_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/segment_crossing_test_top.sv =====
// Segment crossing test for two segments in the XZ plane.
// Input channel in_*: one request per segment pair, eight signed Q15.8
// coordinates packed in in_tdata. Each endpoint of one segment is classed
// against the line of the other by an exact orientation determinant.
// Result channel out_*: one result per request, in request order.
// A request passes through the registered stages difference, multiply,
// determinant sign and output register before its result shows on
// out_tvalid. Throughput: one request per cycle while out_tready stays
// high; the eight 25x25 multipliers sit in the multiply stage.
// Reset (rst_n low, synchronous) empties all stages; out_tvalid drops and
// in_tready rises in the next cycle.
// When the receiver holds out_tready low the result stays on out_tdata,
// earlier stages keep filling bubbles, and in_tready falls only once every
// stage holds a request. Nothing is dropped or repeated.
`default_nettype none
module segment_crossing_test_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // a_start_x, a_start_z, a_end_x, a_end_z, b_start_x, b_start_z, b_end_x, b_end_z
  input  wire logic [scx_pkg::IN_TW-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // crosses, b_start_side, b_end_side, zero fill
  output logic [scx_pkg::OUT_TW-1:0]      out_tdata
);
  import scx_pkg::*;

  logic          s1_vld;
  logic          s1_rdy;
  det_ops_vec_t  s1_ops;
  logic          s2_vld;
  logic          s2_rdy;
  det_prod_vec_t s2_prod;
  logic          s3_vld;
  logic          s3_rdy;
  side_vec_t     s3_sides;

  logic              ovld_r;
  logic [OUT_W-1:0]  res_r;
  logic [OUT_W-1:0]  res_nxt;
  logic              crosses;

  scx_diff u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_tvalid),
    .in_rdy    (in_tready),
    .in_coords (in_tdata[IN_W-1:0]),
    .out_vld   (s1_vld),
    .out_rdy   (s1_rdy),
    .out_ops   (s1_ops)
  );

  scx_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s1_vld),
    .in_rdy   (s1_rdy),
    .in_ops   (s1_ops),
    .out_vld  (s2_vld),
    .out_rdy  (s2_rdy),
    .out_prod (s2_prod)
  );

  scx_det u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s2_vld),
    .in_rdy    (s2_rdy),
    .in_prod   (s2_prod),
    .out_vld   (s3_vld),
    .out_rdy   (s3_rdy),
    .out_sides (s3_sides)
  );

  assign crosses = (s3_sides[DET_BS] != s3_sides[DET_BE]) &&
                   (s3_sides[DET_AS] != s3_sides[DET_AE]);
  assign res_nxt = {s3_sides[DET_BE], s3_sides[DET_BS], crosses};

  assign s3_rdy     = !ovld_r || out_tready;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {{(OUT_TW-OUT_W){1'b0}}, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (s3_rdy) begin
      ovld_r <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s3_vld) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire
